@@ hdl/wvt_pkg.sv @@
`timescale 1ns / 1ps

package wvt_pkg;

    // fixed-point constants of the correlation
    localparam longint KA_Q30      = (64'sd998333 * 64'sd1073741824 + 64'sd500) / 64'sd1000;
    localparam longint KB1_Q30     = -((64'sd81855 * 64'sd1073741824 + 64'sd5000) / 64'sd10000);
    localparam longint KC1_Q30     = (64'sd585 * 64'sd1073741824 + 64'sd50000) / 64'sd100000;
    localparam longint KB2_Q30     = (64'sd13272 * 64'sd1073741824 + 64'sd5000) / 64'sd10000;
    localparam longint KC2_Q30     =
        -((64'sd1053 * 64'sd1073741824 + 64'sd500000) / 64'sd1000000);
    localparam longint SPLIT_Q16   = (64'sd29315 * 64'sd65536 + 64'sd50) / 64'sd100;
    localparam longint POLE_Q16    = (64'sd16815 * 64'sd65536 + 64'sd50) / 64'sd100;
    localparam longint RECIP_NUM   = 64'sd1301 * 64'sd4503599627370496;
    localparam longint KA_Q20      = (KA_Q30 + 64'sd512) / 64'sd1024;
    localparam longint XI_OFFSET   = RECIP_NUM / KA_Q20;
    localparam longint LOG2_10_Q24 =
        (64'sd3321928095 * 64'sd16777216 + 64'sd500000000) / 64'sd1000000000;
    localparam longint LN2_Q32     =
        (64'sd693147181 * 64'sd4294967296 + 64'sd500000000) / 64'sd1000000000;
    localparam longint ONE_Q32     = 64'sd4294967296;
    localparam longint XI_MAX      = 64'sd16 * 64'sd4294967296;
    localparam longint XI_MIN      = -64'sd20 * 64'sd4294967296;
    localparam longint A_MIN       = 64'sd64 * 64'sd1073741824;
    localparam longint XI_BIAS     = 64'sd3 * 64'sd4294967296;
    localparam longint DIV3_RECIP  = 64'sd2863311531;

    // pipeline geometry
    localparam int QW          = 37;
    localparam int FRONT_DEPTH = 4;
    localparam int EXP_DEPTH   = 12;

    // 2^(k/16) in Q30
    localparam longint E2_DEN = 64'sd1000000000;
    localparam longint E2_Q   = 64'sd1073741824;
    localparam longint E2_H   = 64'sd500000000;
    localparam logic [30:0] POW2_TAB [16] = '{
        31'((64'sd1000000000 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1044273782 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1090507733 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1138788635 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1189207115 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1241857812 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1296839555 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1354255547 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1414213562 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1476826146 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1542210825 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1610490332 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1681792831 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1756252160 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1834008086 * E2_Q + E2_H) / E2_DEN),
        31'((64'sd1915206561 * E2_Q + E2_H) / E2_DEN)
    };

    // flags that ride along with each word
    typedef struct packed {
        logic upper;
        logic neg;
        logic sat;
    } t_side;

endpackage

@@ hdl/water_viscosity_from_temperature.sv @@
`timescale 1ns / 1ps
// the o_valid strobe follows an accepted start through the operand, quotient and exponent stages
// throughput: one word per cycle; busy is never raised
// fixed depth: 4 operand stages, 37 quotient stages, 12 exponent stages
// reset clears only the valid bits; the receiver cannot stall the pipe
module water_viscosity_from_temperature #(
    parameter int TEMP_FRAC_BITS = 7,
    parameter int VISC_FRAC_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_temperature,
    output logic        o_valid,
    output logic [31:0] o_viscosity,
    output logic        o_saturated
);

    localparam int LAT = wvt_pkg::FRONT_DEPTH + wvt_pkg::QW + wvt_pkg::EXP_DEPTH;

    logic                   f_valid;
    logic [63:0]            f_dividend;
    logic [30:0]            f_divisor;
    wvt_pkg::t_side         f_side;
    logic                   d_valid;
    logic [wvt_pkg::QW-1:0] d_quot;
    wvt_pkg::t_side         d_side;

    assign busy = 1'b0;

    // operands for the divider
    wvt_front #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_temperature (i_temperature),
        .o_valid       (f_valid),
        .o_dividend    (f_dividend),
        .o_divisor     (f_divisor),
        .o_side        (f_side)
    );

    // pipelined restoring divider
    wvt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_dividend (f_dividend),
        .i_divisor  (f_divisor),
        .i_side     (f_side),
        .o_valid    (d_valid),
        .o_quot     (d_quot),
        .o_side     (d_side)
    );

    // power of ten and output scaling
    wvt_exp #(
        .VISC_FRAC_BITS (VISC_FRAC_BITS)
    ) u_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (d_valid),
        .i_quot      (d_quot),
        .i_side      (d_side),
        .o_valid     (o_valid),
        .o_viscosity (o_viscosity),
        .o_saturated (o_saturated)
    );

    // every accepted word comes out at o_valid after the full pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_valid)
        else $error("result without an accepted word");

    // a clamped result is all ones
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_viscosity == 32'hFFFF_FFFF))
        else $error("saturated result not at maximum");

endmodule

@@ hdl/wvt_front.sv @@
`timescale 1ns / 1ps

module wvt_front #(
    parameter int TEMP_FRAC_BITS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [15:0]        i_temperature,
    output logic               o_valid,
    output logic [63:0]        o_dividend,
    output logic [30:0]        o_divisor,
    output wvt_pkg::t_side     o_side
);

    localparam int TW = 32 - TEMP_FRAC_BITS;

    logic [TW-1:0]       t16;
    logic signed [31:0]  t16s;
    logic                n_up;
    logic signed [31:0]  n_d16;
    logic [30:0]         n_den;

    logic [3:1]          r_v;
    logic signed [31:0]  r_d16_1, r_d16_2;
    logic                r_up_1, r_up_2, r_up_3;
    logic [30:0]         r_den_1, r_den_2, r_den_3;
    logic signed [63:0]  r_p1, r_p2;
    logic signed [63:0]  inner;
    logic signed [63:0]  rs;
    logic signed [63:0]  a;
    logic signed [63:0]  a20;
    logic                a_sat;
    logic [63:0]         mag;
    logic                r_valid;
    logic [63:0]         r_dividend;
    logic [30:0]         r_divisor;
    wvt_pkg::t_side      r_side;

    // temperature to Q16 and offset from the split point
    assign t16   = {i_temperature, {(16 - TEMP_FRAC_BITS){1'b0}}};
    assign t16s  = signed'({{TEMP_FRAC_BITS{1'b0}}, t16});
    assign n_d16 = 32'(wvt_pkg::SPLIT_Q16) - t16s;
    assign n_up  = t16s >= 32'(wvt_pkg::SPLIT_Q16);
    assign n_den = 31'(t16s - 32'(wvt_pkg::POLE_Q16));

    // quadratic inner term and product with d
    assign inner = (r_up_2 ? wvt_pkg::KB2_Q30 : wvt_pkg::KB1_Q30)
                 + ((r_p1 + 64'sd32768) >>> 16);
    assign rs    = (r_p2 + 64'sd32768) >>> 16;
    assign a     = wvt_pkg::KA_Q30 + rs;
    assign a_sat = !r_up_3 && (a < wvt_pkg::A_MIN);
    assign a20   = (a + 64'sd512) >>> 10;
    assign mag   = (rs < 0) ? 64'(-rs) : 64'(rs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[2:1], i_valid};
            r_valid <= r_v[3];
        end
        r_d16_1 <= n_d16;
        r_up_1  <= n_up;
        r_den_1 <= n_den;
        // stage 2: linear coefficient times d
        r_p1    <= (r_up_1 ? wvt_pkg::KC2_Q30 : wvt_pkg::KC1_Q30) * 64'(r_d16_1);
        r_d16_2 <= r_d16_1;
        r_up_2  <= r_up_1;
        r_den_2 <= r_den_1;
        // stage 3: inner term times d
        r_p2    <= inner * 64'(r_d16_2);
        r_up_3  <= r_up_2;
        r_den_3 <= r_den_2;
        // stage 4: divider operands
        r_side.upper <= r_up_3;
        r_side.neg   <= r_up_3 && (rs < 0);
        r_side.sat   <= a_sat;
        r_dividend   <= r_up_3 ? (mag << 18) : 64'(wvt_pkg::RECIP_NUM);
        r_divisor    <= r_up_3 ? r_den_3 : (a_sat ? 31'd1 : a20[30:0]);
    end

    assign o_valid    = r_valid;
    assign o_dividend = r_dividend;
    assign o_divisor  = r_divisor;
    assign o_side     = r_side;

endmodule

@@ hdl/wvt_div.sv @@
`timescale 1ns / 1ps

module wvt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [63:0]               i_dividend,
    input  logic [30:0]               i_divisor,
    input  wvt_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [wvt_pkg::QW-1:0]    o_quot,
    output wvt_pkg::t_side            o_side
);

    localparam int QW = wvt_pkg::QW;

    logic [QW:0]          r_v;
    logic [63:0]          r_rem  [QW+1];
    logic [30:0]          r_dv   [QW+1];
    logic [QW-1:0]        r_q    [QW+1];
    wvt_pkg::t_side       r_sd   [QW+1];

    assign r_v[0]   = i_valid;
    assign r_rem[0] = i_dividend;
    assign r_dv[0]  = i_divisor;
    assign r_q[0]   = '0;
    assign r_sd[0]  = i_side;

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic        ge;
        logic [63:0] n_rem;

        assign ge    = (r_rem[k] >> B) >= {33'd0, r_dv[k]};
        assign n_rem = ge ? r_rem[k] - ({33'd0, r_dv[k]} << B) : r_rem[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1] <= n_rem;
            r_dv[k+1]  <= r_dv[k];
            r_q[k+1]   <= {r_q[k][QW-2:0], ge};
            r_sd[k+1]  <= r_sd[k];
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_q[QW];
    assign o_side  = r_sd[QW];

endmodule

@@ hdl/wvt_exp.sv @@
`timescale 1ns / 1ps

module wvt_exp #(
    parameter int VISC_FRAC_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [wvt_pkg::QW-1:0]    i_quot,
    input  wvt_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [31:0]               o_viscosity,
    output logic                      o_saturated
);

    localparam int QW = wvt_pkg::QW;

    logic [12:1]         r_v;
    logic [11:1]         r_sat;
    logic signed [39:0]  qs, xi, xc;
    logic                xi_sat;
    logic signed [39:0]  r_xm;
    logic signed [63:0]  r_yp;
    logic signed [63:0]  y;
    logic signed [9:0]   r_n  [3:11];
    logic [31:0]         r_f;
    logic [27:0]         r_x  [4:8];
    logic [3:0]          r_idx [4:9];
    logic [63:0]         r_m1, r_d3, r_m2, r_m3, r_mm;
    logic [32:0]         p1, p2, p3, p4;
    logic [31:0]         v3;
    logic [31:0]         r_mant;
    logic [63:0]         xprod;
    logic [33:0]         up_val;
    logic [5:0]          sh;
    logic [71:0]         dn_val;
    logic [31:0]         n_visc;
    logic                n_sat;

    // exponent in Q32 from the quotient
    assign qs = signed'({{(40 - QW){1'b0}}, i_quot});
    always_comb begin
        if (i_side.upper) begin
            xi = i_side.neg ? -qs : qs;
        end else begin
            xi = qs - 40'(wvt_pkg::XI_OFFSET);
        end
        xi_sat = i_side.sat || (xi > 40'(wvt_pkg::XI_MAX));
        xc     = (xi < 40'(wvt_pkg::XI_MIN)) ? 40'(wvt_pkg::XI_MIN) : xi;
    end

    // base-2 exponent
    assign y     = ((r_yp + 64'sd8388608) >>> 24)
                 + (64'(VISC_FRAC_BITS) <<< 32);
    assign xprod = 64'(r_f[27:0]) * 64'(wvt_pkg::LN2_Q32) + 64'd2147483648;

    // series terms
    assign p1 = 33'(wvt_pkg::ONE_Q32) + 33'((r_x[5] + 28'd2) >> 2);
    assign v3 = 32'((r_m1 + 64'd2147483648) >> 32) + 32'd1;
    assign p2 = 33'(wvt_pkg::ONE_Q32) + 33'(r_d3 >> 33);
    assign p3 = 33'(wvt_pkg::ONE_Q32)
              + 33'((((r_m2 + 64'd2147483648) >> 32) + 64'd1) >> 1);
    assign p4 = 33'(wvt_pkg::ONE_Q32) + 33'((r_m3 + 64'd2147483648) >> 32);

    // final scaling by the integer part
    always_comb begin
        n_sat  = r_sat[11] || (r_n[11] >= 10'sd32);
        up_val = {2'b0, r_mant} << 34'(r_n[11] - 10'sd30);
        sh     = 6'(10'sd30 - r_n[11]);
        dn_val = ({40'd0, r_mant} + (72'd1 << (sh - 6'd1))) >> sh;
        n_visc = '0;
        if (r_n[11] >= 10'sd30) begin
            n_visc = up_val[31:0];
            if (up_val[33:32] != 2'b0) begin
                n_sat = 1'b1;
            end
        end else if (r_n[11] >= -10'sd10) begin
            n_visc = dn_val[31:0];
            if (dn_val[71:32] != '0) begin
                n_sat = 1'b1;
            end
        end
        if (n_sat) begin
            n_visc = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[11:1], i_valid};
        end
        r_sat     <= {r_sat[10:1], xi_sat};
        r_xm      <= xc - 40'(wvt_pkg::XI_BIAS);
        r_yp      <= 64'(r_xm) * wvt_pkg::LOG2_10_Q24;
        r_n[3]    <= 10'(y >>> 32);
        r_f       <= y[31:0];
        r_n[4]    <= r_n[3];
        r_x[4]    <= xprod[59:32];
        r_idx[4]  <= r_f[31:28];
        for (int i = 5; i <= 11; i++) begin
            r_n[i] <= r_n[i-1];
        end
        for (int i = 5; i <= 8; i++) begin
            r_x[i] <= r_x[i-1];
        end
        for (int i = 5; i <= 9; i++) begin
            r_idx[i] <= r_idx[i-1];
        end
        r_m1   <= 64'(r_x[5]) * 64'(p1);
        r_d3   <= 64'(v3) * 64'(wvt_pkg::DIV3_RECIP);
        r_m2   <= 64'(r_x[7]) * 64'(p2);
        r_m3   <= 64'(r_x[8]) * 64'(p3);
        r_mm   <= 64'(wvt_pkg::POW2_TAB[r_idx[9]]) * 64'(p4);
        r_mant <= 32'((r_mm + 64'd2147483648) >> 32);
        o_viscosity <= n_visc;
        o_saturated <= n_sat;
    end

    assign o_valid = r_v[12];

endmodule
